[rtl/pgtbl_pkg.sv]
`default_nettype none

package pgtbl_pkg;

	localparam int VA_W = 48;
	localparam int PA_W = 52;
	localparam int NUM_W = 40;
	localparam int FLAG_W = 3;
	localparam int ENTRY_W = NUM_W + FLAG_W;
	localparam int IDX_W = 9;
	localparam int OFS_W = 12;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int LEVELS = 4;

	// Operation codes
	localparam logic OP_MAP    = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
	localparam logic [1:0] STATUS_NO_TABLE = 2'd2;

	// Flags written into an intermediate (link) entry
	localparam logic [FLAG_W-1:0] LINK_FLAGS = 3'b111;

	localparam logic [1:0] LEAF_LEVEL = 2'd3;

	typedef struct packed {
		logic              op;
		logic [VA_W-1:0]   virt_addr;
		logic [NUM_W-1:0]  phys_frame;
		logic [FLAG_W-1:0] flags;
	} req_item_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [PA_W-1:0] phys_addr;
		logic            leaf_present;
		logic            leaf_writable;
		logic            leaf_user;
		logic            invalidate;
	} rsp_item_t;

	// Table index of one walk level: bits 47..39, 38..30, 29..21, 20..12
	function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
			input logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		case (lvl)
			2'd0: idx = va[47:39];
			2'd1: idx = va[38:30];
			2'd2: idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

`default_nettype wire

[rtl/pgtbl_mem.sv]
`default_nettype none

// Simple dual-port table store: one write port, one read port, registered read.
module pgtbl_mem #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15,
	parameter int DW    = 43
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/pgtbl_walk.sv]
`default_nettype none

// Walk sequencer: clearing pass, level reads, table allocation and entry writes.
module pgtbl_walk #(
	parameter int MAX_TABLES = 64,
	parameter int TW         = 6,
	parameter int AW         = 15,
	parameter int CW         = 7
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	output logic                                     req_ready,
	input  wire pgtbl_pkg::req_item_t                req,
	input  wire logic                                rsp_free,
	output logic                                     rsp_load,
	output pgtbl_pkg::rsp_item_t                     result,
	output logic [CW-1:0]                            used,
	output logic                                     mem_we,
	output logic [AW-1:0]                            mem_waddr,
	output logic [pgtbl_pkg::ENTRY_W-1:0]            mem_wdata,
	output logic                                     mem_re,
	output logic [AW-1:0]                            mem_raddr,
	input  wire logic [pgtbl_pkg::ENTRY_W-1:0]       mem_rdata
);

	localparam int DEPTH = MAX_TABLES * pgtbl_pkg::ENTRIES_PER_TABLE;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_EVAL  = 5'b00100,
		ST_LINK  = 5'b01000,
		ST_DONE  = 5'b10000
	} walk_state_t;

	walk_state_t           state_q, state_d;
	logic [AW-1:0]         clr_addr_q, clr_addr_d;
	logic [1:0]            lvl_q, lvl_d;
	logic [TW-1:0]         tn_q, tn_d;
	logic [CW-1:0]         used_q, used_d;
	pgtbl_pkg::req_item_t  item_q, item_d;
	pgtbl_pkg::rsp_item_t  res_q, res_d;

	logic                         entry_empty;
	logic [TW-1:0]                next_tn;
	logic [AW-1:0]                cur_addr;
	logic [AW-1:0]                next_addr;
	logic [1:0]                   need;
	logic [CW:0]                  need_total;
	logic                         no_room;
	logic [pgtbl_pkg::ENTRY_W-1:0] link_entry;
	logic [pgtbl_pkg::ENTRY_W-1:0] leaf_entry;

	assign entry_empty = (mem_rdata == '0);
	assign next_tn     = mem_rdata[pgtbl_pkg::FLAG_W +: TW];
	assign cur_addr    = {tn_q, pgtbl_pkg::level_index(item_q.virt_addr, lvl_q)};
	assign next_addr   = {next_tn, pgtbl_pkg::level_index(item_q.virt_addr, lvl_q + 2'd1)};
	assign need        = 2'd3 - lvl_q;
	assign need_total  = {1'b0, used_q} + (CW+1)'(need);
	assign no_room     = need_total > (CW+1)'(MAX_TABLES);
	assign link_entry  = {pgtbl_pkg::NUM_W'(used_q), pgtbl_pkg::LINK_FLAGS};
	assign leaf_entry  = {item_q.phys_frame, item_q.flags};

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_load  = (state_q == ST_DONE) && rsp_free;
	assign result    = res_q;
	assign used      = used_q;

	always_comb begin
		state_d    = state_q;
		clr_addr_d = clr_addr_q;
		lvl_d      = lvl_q;
		tn_d       = tn_q;
		used_d     = used_q;
		item_d     = item_q;
		res_d      = res_q;
		mem_we     = 1'b0;
		mem_waddr  = cur_addr;
		mem_wdata  = '0;
		mem_re     = 1'b0;
		mem_raddr  = next_addr;
		case (state_q)
			ST_CLEAR: begin
				mem_we     = 1'b1;
				mem_waddr  = clr_addr_q;
				clr_addr_d = clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					item_d    = req;
					lvl_d     = 2'd0;
					tn_d      = '0;
					res_d     = '0;
					mem_re    = 1'b1;
					mem_raddr = {{TW{1'b0}}, pgtbl_pkg::level_index(req.virt_addr, 2'd0)};
					state_d   = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (item_q.op == pgtbl_pkg::OP_LOOKUP) begin
					if (entry_empty) begin
						res_d.status = pgtbl_pkg::STATUS_UNMAPPED;
						state_d      = ST_DONE;
					end else if (lvl_q == pgtbl_pkg::LEAF_LEVEL) begin
						res_d.status        = pgtbl_pkg::STATUS_OK;
						res_d.phys_addr     = {mem_rdata[pgtbl_pkg::ENTRY_W-1:pgtbl_pkg::FLAG_W],
							item_q.virt_addr[pgtbl_pkg::OFS_W-1:0]};
						res_d.leaf_present  = mem_rdata[0];
						res_d.leaf_writable = mem_rdata[1];
						res_d.leaf_user     = mem_rdata[2];
						state_d             = ST_DONE;
					end else begin
						mem_re = 1'b1;
						tn_d   = next_tn;
						lvl_d  = lvl_q + 2'd1;
					end
				end else begin
					if (lvl_q == pgtbl_pkg::LEAF_LEVEL) begin
						// overwrite the leaf; a nonzero old leaf must be dropped downstream
						mem_we           = 1'b1;
						mem_wdata        = leaf_entry;
						res_d.status     = pgtbl_pkg::STATUS_OK;
						res_d.invalidate = !entry_empty;
						state_d          = ST_DONE;
					end else if (entry_empty) begin
						if (no_room) begin
							res_d.status = pgtbl_pkg::STATUS_NO_TABLE;
							state_d      = ST_DONE;
						end else begin
							mem_we    = 1'b1;
							mem_wdata = link_entry;
							tn_d      = used_q[TW-1:0];
							used_d    = used_q + CW'(1);
							lvl_d     = lvl_q + 2'd1;
							state_d   = ST_LINK;
						end
					end else begin
						mem_re = 1'b1;
						tn_d   = next_tn;
						lvl_d  = lvl_q + 2'd1;
					end
				end
			end
			ST_LINK: begin
				// every table below a fresh one is fresh too: write without reading
				mem_we = 1'b1;
				if (lvl_q == pgtbl_pkg::LEAF_LEVEL) begin
					mem_wdata    = leaf_entry;
					res_d.status = pgtbl_pkg::STATUS_OK;
					state_d      = ST_DONE;
				end else begin
					mem_wdata = link_entry;
					tn_d      = used_q[TW-1:0];
					used_d    = used_q + CW'(1);
					lvl_d     = lvl_q + 2'd1;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			used_q     <= CW'(1);
		end else begin
			state_q    <= state_d;
			clr_addr_q <= clr_addr_d;
			used_q     <= used_d;
		end
	end

	always_ff @(posedge clk) begin
		lvl_q  <= lvl_d;
		tn_q   <= tn_d;
		item_q <= item_d;
		res_q  <= res_d;
	end

endmodule

`default_nettype wire

[rtl/four_level_page_table_map_lookup.sv]
`default_nettype none

// Four-level page table map and lookup engine. The tables (MAX_TABLES tables of
// 512 entries, table 0 the root) live in one synchronous table store with a
// registered read. After reset the block runs a clearing pass over all
// MAX_TABLES*512 entries, one entry per cycle, and holds req_ready low until it
// is done. Items are then handled one at a time: a lookup reads one level per
// cycle and a map reads down to the first empty level, then writes one new
// link entry per cycle and finally the leaf. Successive levels are read one
// after another through the single read port. A finished result moves into an
// output register, so the next request is taken while the response waits for
// rsp_ready. A map that needs more tables than remain returns "no free table"
// and changes nothing; invalidate flags a map that replaced a nonzero leaf.
module four_level_page_table_map_lookup #(
	parameter int MAX_TABLES = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire pgtbl_pkg::req_item_t req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output pgtbl_pkg::rsp_item_t      rsp
);

	localparam int TW    = $clog2(MAX_TABLES);
	localparam int AW    = TW + pgtbl_pkg::IDX_W;
	localparam int CW    = $clog2(MAX_TABLES + 1);
	localparam int DEPTH = MAX_TABLES * pgtbl_pkg::ENTRIES_PER_TABLE;

	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [pgtbl_pkg::ENTRY_W-1:0] mem_wdata;
	logic                          mem_re;
	logic [AW-1:0]                 mem_raddr;
	logic [pgtbl_pkg::ENTRY_W-1:0] mem_rdata;

	logic                 rsp_free;
	logic                 rsp_load;
	pgtbl_pkg::rsp_item_t result;
	logic [CW-1:0]        used;

	logic                 rsp_valid_q;
	pgtbl_pkg::rsp_item_t rsp_q;

	// Output slot is free when empty or being drained this cycle
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	pgtbl_walk #(
		.MAX_TABLES (MAX_TABLES),
		.TW         (TW),
		.AW         (AW),
		.CW         (CW)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_free  (rsp_free),
		.rsp_load  (rsp_load),
		.result    (result),
		.used      (used),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Reads and writes of one transaction never touch the store in the same
	// cycle at the same entry: all reads of a walk precede its writes.
	pgtbl_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (pgtbl_pkg::ENTRY_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Hold the response until taken; load a new one when the walk finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= result;
		end
	end

	// One transaction at a time: the walk is busy right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while a walk is in progress");

	// The allocation counter never passes the table budget nor drops the root
	assert property (@(posedge clk) disable iff (!arst_n)
		(used != '0) && (used <= CW'(MAX_TABLES)))
		else $error("table allocation count out of range");

	// Only a successful map may ask for an invalidate
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.invalidate) |->
			(rsp.status == pgtbl_pkg::STATUS_OK) && (rsp.phys_addr == '0))
		else $error("invalidate on a result that is not a successful map");

	// A new response never overwrites one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> !$past(rsp_load))
		else $error("response register overwritten while stalled");

endmodule

`default_nettype wire
